### rtl/gcm_pkg.sv
// ----------------------------------------------------------------------------
// gcm_pkg
// Shared widths, angle classes and the CORDIC arctangent table for the
// great-circle midpoint core.
// ----------------------------------------------------------------------------
`default_nettype none

package gcm_pkg;

    localparam int FRAC_BITS_DEF     = 16;
    localparam int CORDIC_STAGES_DEF = 24;

    localparam int LAT_W = 24;
    localparam int LON_W = 25;

    // rotation components (Q30, a little headroom)
    localparam int VW    = 33;
    // vectoring x/y width
    localparam int VEC_W = 37;
    // vectoring angle accumulator, Q32 degrees
    localparam int ZV_W  = 43;
    // magnitude bits fed to the gain multiply
    localparam int MAG_W = 34;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    localparam logic [29:0] GAIN_K = 30'd652032874;

    localparam logic [1:0] CLS_NORM  = 2'd0;
    localparam logic [1:0] CLS_ZERO  = 2'd1;
    localparam logic [1:0] CLS_POS90 = 2'd2;
    localparam logic [1:0] CLS_NEG90 = 2'd3;

    typedef struct packed {
        logic       flip;
        logic       neg;
        logic [1:0] cls;
    } ang_ctl_t;

    localparam int CTL_W = $bits(ang_ctl_t);

    // width of a scaled input angle in Q32 degrees
    function automatic int ang_width(input int frac);
        int w;
        begin
            w = LON_W + 32 - frac + 2;
            if (w < 41)
                w = 41;
            return w;
        end
    endfunction

    // atan(2^-i) in degrees, Q32
    function automatic logic [38:0] atan_q32(input int i);
        logic [38:0] v;
        begin
            case (i)
                0:  v = 39'd193273528320;
                1:  v = 39'd114096026022;
                2:  v = 39'd60285206653;
                3:  v = 39'd30601712202;
                4:  v = 39'd15360239180;
                5:  v = 39'd7687607524;
                6:  v = 39'd3844741810;
                7:  v = 39'd1922488225;
                8:  v = 39'd961258781;
                9:  v = 39'd480631223;
                10: v = 39'd240315841;
                11: v = 39'd120157949;
                12: v = 39'd60078978;
                13: v = 39'd30039490;
                14: v = 39'd15019745;
                15: v = 39'd7509872;
                16: v = 39'd3754936;
                17: v = 39'd1877468;
                18: v = 39'd938734;
                19: v = 39'd469367;
                20: v = 39'd234684;
                21: v = 39'd117342;
                22: v = 39'd58671;
                23: v = 39'd29335;
                24: v = 39'd14668;
                25: v = 39'd7334;
                26: v = 39'd3667;
                27: v = 39'd1833;
                28: v = 39'd917;
                29: v = 39'd458;
                30: v = 39'd229;
                31: v = 39'd115;
                default: v = 39'd0;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/gcm_fifo.sv
// ----------------------------------------------------------------------------
// gcm_fifo
// Small register FIFO with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`default_nettype none

module gcm_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] din,
    output logic              full,
    input  wire logic         pop,
    output logic [W-1:0]      dout,
    output logic              empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem [0:DEPTH-1];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= din;
    end

endmodule

`default_nettype wire

### rtl/gcm_front.sv
// ----------------------------------------------------------------------------
// gcm_front
// Scales the four input angles to Q32 degrees, folds each into +-90 and
// classifies exact axes for the rotation CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none

module gcm_front #(
    parameter int FRAC_BITS = gcm_pkg::FRAC_BITS_DEF
) (
    input  wire logic signed [gcm_pkg::LAT_W-1:0] start_lat,
    input  wire logic signed [gcm_pkg::LON_W-1:0] start_lon,
    input  wire logic signed [gcm_pkg::LAT_W-1:0] end_lat,
    input  wire logic signed [gcm_pkg::LON_W-1:0] end_lon,
    output logic [4*(gcm_pkg::ang_width(FRAC_BITS)+gcm_pkg::CTL_W)-1:0] word
);

    localparam int Z_W    = gcm_pkg::ang_width(FRAC_BITS);
    localparam int LANE_W = Z_W + gcm_pkg::CTL_W;
    localparam int SH     = 32 - FRAC_BITS;

    localparam logic signed [Z_W-1:0] D90  = Z_W'(64'd90 << 32);
    localparam logic signed [Z_W-1:0] D180 = Z_W'(64'd180 << 32);
    localparam logic signed [Z_W-1:0] D360 = Z_W'(64'd360 << 32);

    function automatic logic [LANE_W-1:0] reduce(input logic signed [Z_W-1:0] a_in);
        logic signed [Z_W-1:0] a;
        logic signed [Z_W-1:0] mag;
        gcm_pkg::ang_ctl_t     c;
        begin
            a      = a_in;
            c.flip = 1'b0;
            if (a >= D180)
                a = a - D360;
            if (a < -D180)
                a = a + D360;
            if (a > D90)
            begin
                a      = a - D180;
                c.flip = 1'b1;
            end
            else if (a < -D90)
            begin
                a      = a + D180;
                c.flip = 1'b1;
            end
            c.neg = a[Z_W-1];
            if (a == '0)
                c.cls = gcm_pkg::CLS_ZERO;
            else if (a == D90)
                c.cls = gcm_pkg::CLS_POS90;
            else if (a == -D90)
                c.cls = gcm_pkg::CLS_NEG90;
            else
                c.cls = gcm_pkg::CLS_NORM;
            mag = c.neg ? -a : a;
            return {c, mag};
        end
    endfunction

    logic signed [Z_W-1:0] a_lat1, a_lon1, a_lat2, a_lon2;

    assign a_lat1 = {{(Z_W-gcm_pkg::LAT_W){start_lat[gcm_pkg::LAT_W-1]}}, start_lat} << SH;
    assign a_lon1 = {{(Z_W-gcm_pkg::LON_W){start_lon[gcm_pkg::LON_W-1]}}, start_lon} << SH;
    assign a_lat2 = {{(Z_W-gcm_pkg::LAT_W){end_lat[gcm_pkg::LAT_W-1]}}, end_lat} << SH;
    assign a_lon2 = {{(Z_W-gcm_pkg::LON_W){end_lon[gcm_pkg::LON_W-1]}}, end_lon} << SH;

    // lane order: lat1, lon1, lat2, lon2
    assign word = {reduce(a_lon2), reduce(a_lat2), reduce(a_lon1), reduce(a_lat1)};

endmodule

`default_nettype wire

### rtl/gcm_vec.sv
// ----------------------------------------------------------------------------
// gcm_vec
// Pipelined CORDIC vectoring: atan2(y, x) in Q32 degrees and the gain-scaled
// magnitude, one stage per cycle while en is high, sideband carried along.
// ----------------------------------------------------------------------------
`default_nettype none

module gcm_vec #(
    parameter int W  = gcm_pkg::VEC_W,
    parameter int ZW = gcm_pkg::ZV_W,
    parameter int N  = gcm_pkg::CORDIC_STAGES_DEF,
    parameter int SW = 1
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire logic signed [W-1:0] in_x,
    input  wire logic signed [W-1:0] in_y,
    input  wire logic [SW-1:0]       in_side,
    output logic                     out_valid,
    output logic signed [W-1:0]      out_x,
    output logic signed [ZW-1:0]     out_z,
    output logic [SW-1:0]            out_side
);

    localparam logic signed [ZW-1:0] D180 = ZW'(64'd180 << 32);

    logic                 v_reg    [0:N];
    logic signed [W-1:0]  x_reg    [0:N];
    logic signed [W-1:0]  y_reg    [0:N];
    logic signed [ZW-1:0] z_reg    [0:N];
    logic [SW-1:0]        side_reg [0:N];

    // pre-rotation into the right half plane
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            if (in_x[W-1])
            begin
                x_reg[0] <= -in_x;
                y_reg[0] <= -in_y;
                z_reg[0] <= in_y[W-1] ? -D180 : D180;
            end
            else
            begin
                x_reg[0] <= in_x;
                y_reg[0] <= in_y;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        localparam logic signed [ZW-1:0] AT = ZW'(gcm_pkg::atan_q32(i));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else if (en)
                v_reg[i+1] <= v_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[i+1] <= side_reg[i];
                if (!y_reg[i][W-1])
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + AT;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - AT;
                end
            end
        end
    end

    assign out_valid = v_reg[N];
    assign out_x     = x_reg[N];
    assign out_z     = z_reg[N];
    assign out_side  = side_reg[N];

endmodule

`default_nettype wire

### rtl/gcm_back.sv
// ----------------------------------------------------------------------------
// gcm_back
// Sine/cosine by rotation CORDIC, unit-vector sum, longitude and latitude
// by two vectoring CORDICs, clamp and rounding. Whole pipe moves on en.
// ----------------------------------------------------------------------------
`default_nettype none

module gcm_back #(
    parameter int FRAC_BITS     = gcm_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = gcm_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_empty,
    input  wire logic [4*(gcm_pkg::ang_width(FRAC_BITS)+gcm_pkg::CTL_W)-1:0] q_word,
    output logic      q_pop,
    input  wire logic o_full,
    output logic      o_push,
    output logic [gcm_pkg::LAT_W+gcm_pkg::LON_W:0] o_word
);

    localparam int N      = CORDIC_STAGES;
    localparam int Z_W    = gcm_pkg::ang_width(FRAC_BITS);
    localparam int LANE_W = Z_W + gcm_pkg::CTL_W;
    localparam int VW     = gcm_pkg::VW;
    localparam int VEC_W  = gcm_pkg::VEC_W;
    localparam int ZV_W   = gcm_pkg::ZV_W;
    localparam int MAG_W  = gcm_pkg::MAG_W;
    localparam int SH     = 32 - FRAC_BITS;
    localparam int LAT_W  = gcm_pkg::LAT_W;
    localparam int LON_W  = gcm_pkg::LON_W;
    localparam int SIDE1  = VEC_W + 1;
    localparam int SIDE2  = ZV_W + 3;

    localparam logic signed [VW-1:0]   ONE_Q30 = VW'(64'd1 << 30);
    localparam logic signed [VW-1:0]   K_Q30   = VW'(gcm_pkg::GAIN_K);
    localparam logic signed [ZV_W-1:0] D90     = ZV_W'(64'd90 << 32);
    localparam logic signed [ZV_W-1:0] D180    = ZV_W'(64'd180 << 32);
    localparam logic signed [ZV_W:0]   HALF    = (ZV_W+1)'(64'd1 << (SH - 1));

    // Q30 product, magnitude rounded half away from zero
    function automatic logic signed [VW:0] mul_q30(input logic signed [VW-1:0] a,
                                                   input logic signed [VW-1:0] b);
        logic [VW-1:0]   ua, ub;
        logic [2*VW-1:0] p;
        logic [VW-1:0]   r;
        begin
            ua = a[VW-1] ? VW'(-a) : VW'(a);
            ub = b[VW-1] ? VW'(-b) : VW'(b);
            p  = ua * ub;
            p  = p + (2*VW)'(64'd1 << 29);
            r  = p[30 +: VW];
            return (a[VW-1] != b[VW-1]) ? -$signed({1'b0, r}) : $signed({1'b0, r});
        end
    endfunction

    function automatic logic signed [ZV_W-1:0] clamp(input logic signed [ZV_W-1:0] v,
                                                     input logic signed [ZV_W-1:0] lim);
        begin
            if (v > lim)
                return lim;
            if (v < -lim)
                return -lim;
            return v;
        end
    endfunction

    logic en;
    assign en    = !o_full;
    assign q_pop = en && !q_empty;

    // ---------------- rotation CORDIC, four lanes ----------------
    logic                  rv_reg  [0:N];
    logic signed [VW-1:0]  rx_reg  [0:N][0:3];
    logic signed [VW-1:0]  ry_reg  [0:N][0:3];
    logic signed [Z_W-1:0] rz_reg  [0:N][0:3];
    gcm_pkg::ang_ctl_t     ctl_reg [0:N][0:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rv_reg[0] <= 1'b0;
        else if (en)
            rv_reg[0] <= !q_empty;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 4; l++)
            begin
                rx_reg[0][l]  <= K_Q30;
                ry_reg[0][l]  <= '0;
                rz_reg[0][l]  <= q_word[l*LANE_W +: Z_W];
                ctl_reg[0][l] <= q_word[l*LANE_W + Z_W +: gcm_pkg::CTL_W];
            end
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_rot
        localparam logic signed [Z_W-1:0] AT = Z_W'(gcm_pkg::atan_q32(i));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rv_reg[i+1] <= 1'b0;
            else if (en)
                rv_reg[i+1] <= rv_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int l = 0; l < 4; l++)
                begin
                    ctl_reg[i+1][l] <= ctl_reg[i][l];
                    if (!rz_reg[i][l][Z_W-1])
                    begin
                        rx_reg[i+1][l] <= rx_reg[i][l] - (ry_reg[i][l] >>> i);
                        ry_reg[i+1][l] <= ry_reg[i][l] + (rx_reg[i][l] >>> i);
                        rz_reg[i+1][l] <= rz_reg[i][l] - AT;
                    end
                    else
                    begin
                        rx_reg[i+1][l] <= rx_reg[i][l] + (ry_reg[i][l] >>> i);
                        ry_reg[i+1][l] <= ry_reg[i][l] - (rx_reg[i][l] >>> i);
                        rz_reg[i+1][l] <= rz_reg[i][l] + AT;
                    end
                end
            end
        end
    end

    // ---------------- axis fix-up, sign and quadrant ----------------
    logic                 pv_reg;
    logic signed [VW-1:0] sn_reg [0:3];
    logic signed [VW-1:0] cs_reg [0:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= 1'b0;
        else if (en)
            pv_reg <= rv_reg[N];
    end

    always_ff @(posedge clk)
    begin
        logic signed [VW-1:0] x, y;
        if (en)
        begin
            for (int l = 0; l < 4; l++)
            begin
                x = rx_reg[N][l];
                y = ry_reg[N][l];
                case (ctl_reg[N][l].cls)
                    gcm_pkg::CLS_ZERO:
                    begin
                        x = ONE_Q30;
                        y = '0;
                    end
                    gcm_pkg::CLS_POS90:
                    begin
                        x = '0;
                        y = ONE_Q30;
                    end
                    gcm_pkg::CLS_NEG90:
                    begin
                        x = '0;
                        y = -ONE_Q30;
                    end
                    default:
                    begin
                        if (ctl_reg[N][l].neg)
                            y = -y;
                    end
                endcase
                if (ctl_reg[N][l].flip)
                begin
                    x = -x;
                    y = -y;
                end
                sn_reg[l] <= y;
                cs_reg[l] <= x;
            end
        end
    end

    // ---------------- products ----------------
    logic               mv_reg;
    logic signed [VW:0] pxa_reg, pxb_reg, pya_reg, pyb_reg, sz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mv_reg <= 1'b0;
        else if (en)
            mv_reg <= pv_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxa_reg <= mul_q30(cs_reg[0], cs_reg[1]);
            pxb_reg <= mul_q30(cs_reg[2], cs_reg[3]);
            pya_reg <= mul_q30(cs_reg[0], sn_reg[1]);
            pyb_reg <= mul_q30(cs_reg[2], sn_reg[3]);
            sz_reg  <= (VW+1)'(sn_reg[0]) + (VW+1)'(sn_reg[2]);
        end
    end

    // ---------------- vector sum ----------------
    logic                    sv_reg;
    logic signed [VEC_W-1:0] vx_reg, vy_reg, vz_reg;
    logic                    pole_reg;
    logic signed [VW+1:0]    vx_sum, vy_sum;

    assign vx_sum = (VW+2)'(pxa_reg) + (VW+2)'(pxb_reg);
    assign vy_sum = (VW+2)'(pya_reg) + (VW+2)'(pyb_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sv_reg <= 1'b0;
        else if (en)
            sv_reg <= mv_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx_reg   <= VEC_W'(vx_sum);
            vy_reg   <= VEC_W'(vy_sum);
            vz_reg   <= VEC_W'(sz_reg);
            pole_reg <= (vx_sum == '0) && (vy_sum == '0);
        end
    end

    // ---------------- longitude ----------------
    logic                    v1_valid;
    logic signed [VEC_W-1:0] v1_mag;
    logic signed [ZV_W-1:0]  v1_z;
    logic [SIDE1-1:0]        v1_side;

    gcm_vec #(
        .W  (VEC_W),
        .ZW (ZV_W),
        .N  (N),
        .SW (SIDE1)
    ) u_vec_lon (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sv_reg),
        .in_x      (vx_reg),
        .in_y      (vy_reg),
        .in_side   ({pole_reg, vz_reg}),
        .out_valid (v1_valid),
        .out_x     (v1_mag),
        .out_z     (v1_z),
        .out_side  (v1_side)
    );

    // ---------------- gain removal on the xy magnitude ----------------
    logic                    hv_reg;
    logic signed [VEC_W-1:0] h_reg;
    logic signed [ZV_W-1:0]  lon_reg;
    logic signed [VEC_W-1:0] hz_reg;
    logic                    hpole_reg;
    logic [MAG_W-1:0]        mag_abs;
    logic [MAG_W+29:0]       mag_prod;
    logic [MAG_W-1:0]        mag_r;

    assign mag_abs  = v1_mag[VEC_W-1] ? MAG_W'(-v1_mag) : MAG_W'(v1_mag);
    assign mag_prod = mag_abs * gcm_pkg::GAIN_K + (MAG_W+30)'(64'd1 << 29);
    assign mag_r    = mag_prod[30 +: MAG_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hv_reg <= 1'b0;
        else if (en)
            hv_reg <= v1_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_reg     <= v1_mag[VEC_W-1] ? -VEC_W'(mag_r) : VEC_W'(mag_r);
            lon_reg   <= clamp(v1_z, D180);
            hz_reg    <= v1_side[VEC_W-1:0];
            hpole_reg <= v1_side[VEC_W];
        end
    end

    // ---------------- latitude ----------------
    logic                    v2_valid;
    logic signed [VEC_W-1:0] v2_mag;
    logic signed [ZV_W-1:0]  v2_z;
    logic [SIDE2-1:0]        v2_side;

    gcm_vec #(
        .W  (VEC_W),
        .ZW (ZV_W),
        .N  (N),
        .SW (SIDE2)
    ) u_vec_lat (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (hv_reg),
        .in_x      (h_reg),
        .in_y      (hz_reg),
        .in_side   ({hpole_reg, (hz_reg == '0), hz_reg[VEC_W-1], lon_reg}),
        .out_valid (v2_valid),
        .out_x     (v2_mag),
        .out_z     (v2_z),
        .out_side  (v2_side)
    );

    // ---------------- select, round, hand to output queue ----------------
    logic                   f_pole, f_zz, f_zneg, f_valid;
    logic signed [ZV_W-1:0] f_lat, f_lon;
    logic signed [ZV_W:0]   lat_rnd, lon_rnd;
    logic [VEC_W-1:0]       mag_unused;

    assign mag_unused = v2_mag;
    assign f_pole = v2_side[ZV_W+2];
    assign f_zz   = v2_side[ZV_W+1];
    assign f_zneg = v2_side[ZV_W];

    always_comb
    begin
        f_valid = 1'b1;
        if (f_pole)
        begin
            f_lon = '0;
            if (f_zz)
            begin
                f_lat   = '0;
                f_valid = 1'b0;
            end
            else
                f_lat = f_zneg ? -D90 : D90;
        end
        else
        begin
            f_lon = v2_side[ZV_W-1:0];
            f_lat = clamp(v2_z, D90);
        end
        lat_rnd = ((ZV_W+1)'(f_lat) + HALF) >>> SH;
        lon_rnd = ((ZV_W+1)'(f_lon) + HALF) >>> SH;
    end

    assign o_push = en && v2_valid;
    assign o_word = {lat_rnd[LAT_W-1:0], lon_rnd[LON_W-1:0], f_valid};

endmodule

`default_nettype wire

### rtl/great_circle_midpoint_core.sv
// ----------------------------------------------------------------------------
// great_circle_midpoint_core
// Great-circle midpoint of two lat/lon points in fixed-point degrees.
//
//   channel | handshake    | words
//   --------+--------------+-------------------------------------------
//   input   | push / full  | start_lat, start_lon, end_lat, end_lon
//   result  | pop / empty  | mid_lat, mid_lon, mid_valid
//
// One word in and one out per cycle, sustained while the result queue has room.
// Results pass through the rotation CORDIC and the two vectoring CORDICs (one
// stage per cycle each) plus axis fix-up, product, sum and gain-removal stages.
// Reset clears queue pointers, queue counts and pipeline valids only.
// A full result queue freezes the back pipe; the input queue keeps taking
// words until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module great_circle_midpoint_core #(
    parameter int FRAC_BITS     = gcm_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = gcm_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic signed [gcm_pkg::LAT_W-1:0]  start_lat,
    input  wire logic signed [gcm_pkg::LON_W-1:0]  start_lon,
    input  wire logic signed [gcm_pkg::LAT_W-1:0]  end_lat,
    input  wire logic signed [gcm_pkg::LON_W-1:0]  end_lon,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic signed [gcm_pkg::LAT_W-1:0]       mid_lat,
    output logic signed [gcm_pkg::LON_W-1:0]       mid_lon,
    output logic                                   mid_valid
);

    localparam int MID_W = 4 * (gcm_pkg::ang_width(FRAC_BITS) + gcm_pkg::CTL_W);
    localparam int OUT_W = gcm_pkg::LAT_W + gcm_pkg::LON_W + 1;

    logic [MID_W-1:0] front_word, mid_word;
    logic             mid_empty, mid_pop;
    logic             out_full, out_push;
    logic [OUT_W-1:0] back_word, out_word;

    gcm_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .start_lat (start_lat),
        .start_lon (start_lon),
        .end_lat   (end_lat),
        .end_lon   (end_lon),
        .word      (front_word)
    );

    gcm_fifo #(
        .W     (MID_W),
        .DEPTH (gcm_pkg::MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (front_word),
        .full  (full),
        .pop   (mid_pop),
        .dout  (mid_word),
        .empty (mid_empty)
    );

    gcm_back #(
        .FRAC_BITS     (FRAC_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (mid_empty),
        .q_word  (mid_word),
        .q_pop   (mid_pop),
        .o_full  (out_full),
        .o_push  (out_push),
        .o_word  (back_word)
    );

    gcm_fifo #(
        .W     (OUT_W),
        .DEPTH (gcm_pkg::OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .din   (back_word),
        .full  (out_full),
        .pop   (pop),
        .dout  (out_word),
        .empty (empty)
    );

    assign mid_lat   = out_word[OUT_W-1 -: gcm_pkg::LAT_W];
    assign mid_lon   = out_word[gcm_pkg::LON_W:1];
    assign mid_valid = out_word[0];

endmodule

`default_nettype wire

### dv/gcm_checker.sv
// ----------------------------------------------------------------------------
// gcm_checker
// Watches the coordinate and midpoint channels of the midpoint core, works
// out each expected midpoint with a bit-exact CORDIC model and compares.
// ----------------------------------------------------------------------------
module gcm_checker #(
    parameter int FRAC_BITS     = gcm_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = gcm_pkg::CORDIC_STAGES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    input  logic                               full,
    input  logic signed [gcm_pkg::LAT_W-1:0]   start_lat,
    input  logic signed [gcm_pkg::LON_W-1:0]   start_lon,
    input  logic signed [gcm_pkg::LAT_W-1:0]   end_lat,
    input  logic signed [gcm_pkg::LON_W-1:0]   end_lon,
    input  logic                               empty,
    input  logic                               pop,
    input  logic signed [gcm_pkg::LAT_W-1:0]   mid_lat,
    input  logic signed [gcm_pkg::LON_W-1:0]   mid_lon,
    input  logic                               mid_valid,
    output int                                 fail_count,
    output int                                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [gcm_pkg::LAT_W-1:0] lat;
        logic signed [gcm_pkg::LON_W-1:0] lon;
        logic                             valid;
    } midpoint_t;

    localparam longint ONE_Q30 = 64'sd1 <<< 30;
    localparam longint K_GAIN  = 64'sd652032874;
    localparam longint D90     = 64'sd90 <<< 32;
    localparam longint D180    = 64'sd180 <<< 32;
    localparam longint D360    = 64'sd360 <<< 32;

    midpoint_t expected_mids[$];

    function automatic int n_stages();
        return (CORDIC_STAGES > 32) ? 32 : ((CORDIC_STAGES < 0) ? 0 : CORDIC_STAGES);
    endfunction

    function automatic longint atan_deg(input int i);
        longint t [32] = '{64'd193273528320, 64'd114096026022, 64'd60285206653,
            64'd30601712202, 64'd15360239180, 64'd7687607524, 64'd3844741810,
            1922488225, 961258781, 480631223,
            240315841, 120157949, 60078978, 30039490, 15019745, 7509872, 3754936,
            1877468, 938734, 469367, 234684, 117342, 58671, 29335, 14668, 7334,
            3667, 1833, 917, 458, 229, 115};
        return t[i];
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        logic       neg;
        longint unsigned ua, ub, r;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        r = (ua * ub + (64'd1 << 29)) >> 30;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    task automatic sincos(input longint a, output longint s, output longint c);
        logic   flip, neg;
        longint x, y, z, dx, dy;
        flip = 0;
        if (a >= D180) a -= D360;
        if (a < -D180) a += D360;
        if (a > D90) begin a -= D180; flip = 1; end
        else if (a < -D90) begin a += D180; flip = 1; end
        if (a == 0) begin x = ONE_Q30; y = 0; end
        else if (a == D90) begin x = 0; y = ONE_Q30; end
        else if (a == -D90) begin x = 0; y = -ONE_Q30; end
        else
        begin
            neg = a < 0;
            x = K_GAIN; y = 0; z = neg ? -a : a;
            for (int i = 0; i < n_stages(); i++)
            begin
                dx = y >>> i; dy = x >>> i;
                if (z >= 0) begin x -= dx; y += dy; z -= atan_deg(i); end
                else begin x += dx; y -= dy; z += atan_deg(i); end
            end
            if (neg) y = -y;
        end
        if (flip) begin x = -x; y = -y; end
        s = y; c = x;
    endtask

    task automatic vector_atan(input longint y, input longint x,
                               output longint ang, output longint mag);
        longint z, dx, dy;
        z = 0;
        if (x < 0)
        begin
            z = (y >= 0) ? D180 : -D180;
            x = -x; y = -y;
        end
        for (int i = 0; i < n_stages(); i++)
        begin
            dx = y >>> i; dy = x >>> i;
            if (y >= 0) begin x += dx; y -= dy; z += atan_deg(i); end
            else begin x -= dx; y += dy; z -= atan_deg(i); end
        end
        ang = z; mag = x;
    endtask

    function automatic longint clip(input longint v, input longint lim);
        return (v > lim) ? lim : ((v < -lim) ? -lim : v);
    endfunction

    function automatic longint round_out(input longint a);
        int sh;
        sh = 32 - FRAC_BITS;
        return (a + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    task automatic predict_midpoint(output midpoint_t m);
        longint s1, c1, sl1, cl1, s2, c2, sl2, cl2, vx, vy, vz, lat, lon, mag, h, junk;
        longint r_lat, r_lon;
        int sh;
        sh = 32 - FRAC_BITS;
        sincos(longint'(start_lat) <<< sh, s1, c1);
        sincos(longint'(start_lon) <<< sh, sl1, cl1);
        sincos(longint'(end_lat) <<< sh, s2, c2);
        sincos(longint'(end_lon) <<< sh, sl2, cl2);
        vx = qmul(c1, cl1) + qmul(c2, cl2);
        vy = qmul(c1, sl1) + qmul(c2, sl2);
        vz = s1 + s2;
        m.valid = 1;
        if (vx == 0 && vy == 0)
        begin
            lon = 0;
            if (vz == 0) begin lat = 0; m.valid = 0; end
            else lat = (vz > 0) ? D90 : -D90;
        end
        else
        begin
            vector_atan(vy, vx, lon, mag);
            lon = clip(lon, D180);
            h = qmul(mag, K_GAIN);
            vector_atan(vz, h, lat, junk);
            lat = clip(lat, D90);
        end
        r_lat = round_out(lat);
        r_lon = round_out(lon);
        m.lat = r_lat[gcm_pkg::LAT_W-1:0];
        m.lon = r_lon[gcm_pkg::LON_W-1:0];
    endtask

    assign pending = expected_mids.size();

    always @(posedge clk or negedge rst_n)
    begin
        midpoint_t e;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (push && !full)
            begin
                predict_midpoint(e);
                expected_mids.push_back(e);
            end
            if (pop && !empty)
            begin
                if (expected_mids.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected midpoint word lat=%0d lon=%0d v=%0b",
                                 mid_lat, mid_lon, mid_valid);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_mids.pop_front();
                    if (e.lat !== mid_lat || e.lon !== mid_lon || e.valid !== mid_valid)
                    begin
                        if (fail_count < 10)
                            $display({"midpoint mismatch: exp lat=%0d lon=%0d v=%0b,",
                                      " got lat=%0d lon=%0d v=%0b"},
                                     e.lat, e.lon, e.valid, mid_lat, mid_lon, mid_valid);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

### dv/tb_great_circle_midpoint_core.sv
// ----------------------------------------------------------------------------
// tb_great_circle_midpoint_core
// Drives coordinate pairs in bursts into the midpoint core with a stalling
// reader; the checker predicts and compares every midpoint word.
// ----------------------------------------------------------------------------
module tb_great_circle_midpoint_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LAT_MAX = 5898240;
    localparam int LON_MAX = 11796480;
    localparam int N_RANDOM = 500;
    localparam int IDLE_LIMIT = 20000;

    logic clk = 0;
    logic rst_n = 0;
    logic push = 0;
    logic pop = 0;
    logic full, empty, mid_valid;
    logic signed [gcm_pkg::LAT_W-1:0] start_lat = 0, end_lat = 0, mid_lat;
    logic signed [gcm_pkg::LON_W-1:0] start_lon = 0, end_lon = 0, mid_lon;
    int fail_count, pending;
    int idle_cycles = 0;
    int pop_phase = 0;

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    great_circle_midpoint_core DUT (.*);

    gcm_checker checker_i (.*);

    // receiver: periodic stall pattern with random stretches
    always @(posedge clk)
    begin
        pop_phase <= pop_phase + 1;
        if (pop_phase % 200 < 60)
            pop <= 1;
        else if (pop_phase % 7 == 3)
            pop <= 0;
        else
            pop <= ($urandom_range(0, 3) != 0);
    end

    // stall watchdog
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int rand_lat();
        case ($urandom_range(0, 9))
            0: return LAT_MAX;
            1: return -LAT_MAX;
            2: return 0;
            3: return $urandom() & 24'hFFFFFF;  // full field, out of range too
            default: return $urandom_range(0, 2 * LAT_MAX) - LAT_MAX;
        endcase
    endfunction

    function automatic int rand_lon();
        case ($urandom_range(0, 9))
            0: return LON_MAX;
            1: return -LON_MAX;
            2: return 0;
            3: return $urandom() & 25'h1FFFFFF;
            default: return $urandom_range(0, 2 * LON_MAX) - LON_MAX;
        endcase
    endfunction

    task automatic send_word(input int la1, input int lo1, input int la2, input int lo2);
        push <= 1;
        start_lat <= la1[gcm_pkg::LAT_W-1:0];
        start_lon <= lo1[gcm_pkg::LON_W-1:0];
        end_lat   <= la2[gcm_pkg::LAT_W-1:0];
        end_lon   <= lo2[gcm_pkg::LON_W-1:0];
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    task automatic send_gap();
        int g;
        g = $urandom_range(0, 6);
        if (g > 0)
        begin
            push <= 0;
            repeat (g) @(posedge clk);
        end
    endtask

    initial
    begin
        int la, lo, burst;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: extremes, exact axes, poles, antipodes
        send_word(0, 0, 0, 0);
        send_word(LAT_MAX, 0, LAT_MAX, 0);
        send_word(-LAT_MAX, 0, -LAT_MAX, 12345);
        send_word(LAT_MAX, 0, -LAT_MAX, 0);
        send_word(0, 0, 0, -LON_MAX);
        send_word(0, LON_MAX, 0, 0);
        send_word(0, 90 <<< 16, 0, -(90 <<< 16));
        send_word(30 <<< 16, 45 <<< 16, -(30 <<< 16), -(135 <<< 16));
        send_word(0, LON_MAX, 0, -LON_MAX);
        send_word(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
        send_word(24'h7FFFFF, 25'hFFFFFF, 24'h800000, 25'h1000000);
        send_word(24'hFFFFFF, 25'h1FFFFFF, 1, 1);
        send_word(0, 25'h0FFFFFF, 0, 25'h1000000);
        send_word(100 <<< 16, 0, 80 <<< 16, 0);
        send_word(1, -1, -1, 1);
        send_word(45 <<< 16, 10 <<< 16, 45 <<< 16, 10 <<< 16);
        send_gap();
        // random: bursts, some antipodal pairs
        for (int n = 0; n < N_RANDOM; )
        begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst; b++, n++)
            begin
                la = rand_lat();
                lo = rand_lon();
                if ($urandom_range(0, 19) == 0)
                    send_word(la, lo, -la, (lo >= 0) ? lo - (180 <<< 16) : lo + (180 <<< 16));
                else
                    send_word(la, lo, rand_lat(), rand_lon());
            end
            send_gap();
        end
        push <= 0;
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
